// File: hw/rtl/sqtc_pkg.sv
// ============================================================================
// sqtc_pkg
// Shared types, constants and helper functions for the SQL token classifier:
// character classes, window entry layout, keyword table and byte tests.
// ============================================================================
package sqtc_pkg;

    // Default number of window cells
    localparam int SQTC_WINDOW_DEPTH = 7;

    // Keyword table geometry
    localparam int KW_COUNT = 21;
    localparam int KW_MAX   = 6;

    // Byte codes used by the string and operator logic
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Character class codes
    typedef enum logic [1:0] {
        CLS_PLAIN    = 2'd0,
        CLS_KEYWORD  = 2'd1,
        CLS_OPERATOR = 2'd2,
        CLS_STRING   = 2'd3
    } sqtc_class_t;

    // One window entry
    typedef struct packed {
        logic        valid;
        logic [7:0]  ch;
        sqtc_class_t cls;
        logic        le;
    } sqtc_entry_t;

    // Per-cell control from the top level and the matcher
    typedef struct packed {
        logic shift;
        logic load;
        logic mark_kw;
        logic mark_op;
    } sqtc_cell_ctl_t;

    // Keyword letters, upper case, padded with NUL
    localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX] = '{
        '{"A", "L", "T", "E", "R", CH_NUL},
        '{"A", "N", "D", CH_NUL, CH_NUL, CH_NUL},
        '{"A", "S", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"A", "S", "C", CH_NUL, CH_NUL, CH_NUL},
        '{"B", "Y", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"D", "E", "L", "E", "T", "E"},
        '{"D", "E", "S", "C", CH_NUL, CH_NUL},
        '{"D", "R", "O", "P", CH_NUL, CH_NUL},
        '{"F", "R", "O", "M", CH_NUL, CH_NUL},
        '{"I", "N", "N", "E", "R", CH_NUL},
        '{"I", "N", "S", "E", "R", "T"},
        '{"I", "S", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"J", "O", "I", "N", CH_NUL, CH_NUL},
        '{"L", "E", "F", "T", CH_NUL, CH_NUL},
        '{"N", "U", "L", "L", CH_NUL, CH_NUL},
        '{"O", "N", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"O", "R", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"O", "R", "D", "E", "R", CH_NUL},
        '{"R", "I", "G", "H", "T", CH_NUL},
        '{"S", "E", "L", "E", "C", "T"},
        '{"W", "H", "E", "R", "E", CH_NUL}
    };

    // Keyword lengths, same order as KW_CHARS
    localparam int KW_LEN [KW_COUNT] = '{
        5, 3, 2, 3, 2, 6, 4, 4, 4, 5, 6, 2, 4, 4, 4, 2, 2, 5, 5, 6, 5
    };

    // Whitespace: TAB..CR and space
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // ASCII lower to upper; everything else unchanged
    function automatic logic [7:0] upper_ascii(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
    endfunction

    // Single-character operators
    function automatic logic is_single_op(input logic [7:0] c);
        return (c == "*") || (c == "/") || (c == "+") || (c == "-") || (c == "%") ||
               (c == "=") || (c == ";") || (c == "<") || (c == ">");
    endfunction

endpackage

// File: hw/rtl/sqtc_in_if.sv
// ============================================================================
// sqtc_in_if
// Input channel: one text byte per transaction, with a line end mark.
// ============================================================================
interface sqtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;

    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

// File: hw/rtl/sqtc_out_if.sv
// ============================================================================
// sqtc_out_if
// Output channel: one classified byte per transaction.
// ============================================================================
interface sqtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] char_class;
    logic       out_line_end;

    modport source (output valid, output out_byte, output char_class, output out_line_end,
                    input ready);
    modport sink   (input valid, input out_byte, input char_class, input out_line_end,
                    output ready);
endinterface

// File: hw/rtl/sqtc_cell.sv
// ============================================================================
// sqtc_cell
// One window cell: holds a byte, its class and its line end mark. Applies
// the marks for its position and hands the marked entry to its neighbor.
// ============================================================================
module sqtc_cell
    import sqtc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  sqtc_cell_ctl_t ctl,
    input  sqtc_entry_t    nbr_view,
    input  sqtc_entry_t    new_entry,
    output sqtc_entry_t    entry,
    output sqtc_entry_t    view
);

    logic        valid_reg, valid_next;
    logic [7:0]  ch_reg, ch_next;
    sqtc_class_t cls_reg, cls_next;
    logic        le_reg, le_next;
    sqtc_entry_t src;

    // Raw stored entry for the matcher
    assign entry = '{valid: valid_reg, ch: ch_reg, cls: cls_reg, le: le_reg};

    // Stored entry with this cycle's marks applied
    always_comb
    begin
        view.valid = valid_reg;
        view.ch    = ch_reg;
        view.le    = le_reg;
        if (ctl.mark_op)
            view.cls = CLS_OPERATOR;
        else if (ctl.mark_kw)
            view.cls = CLS_KEYWORD;
        else
            view.cls = cls_reg;
    end

    // Next entry: new byte, neighbor's entry on a shift, or hold
    always_comb
    begin
        if (ctl.load)
            src = new_entry;
        else if (ctl.shift)
            src = nbr_view;
        else
            src = view;
        valid_next = src.valid;
        ch_next    = src.ch;
        cls_next   = src.cls;
        le_next    = src.le;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        cls_reg <= cls_next;
        le_reg  <= le_next;
    end

endmodule

// File: hw/rtl/sqtc_matcher.sv
// ============================================================================
// sqtc_matcher
// Keyword and "!=" detection over the window plus the incoming byte.
// Produces per-cell mark bits and the keyword mark for the incoming byte.
// ============================================================================
module sqtc_matcher
    import sqtc_pkg::*;
#(
    parameter int WINDOW_DEPTH = SQTC_WINDOW_DEPTH,
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1)
)
(
    input  sqtc_entry_t             cells [WINDOW_DEPTH],
    input  sqtc_entry_t             new_entry,
    input  logic                    accept,
    input  logic [CNT_W-1:0]        cnt,
    input  logic                    before_space,
    output logic [WINDOW_DEPTH-1:0] mark_kw,
    output logic [WINDOW_DEPTH-1:0] mark_op,
    output logic                    new_kw
);

    sqtc_entry_t v [WINDOW_DEPTH+1];
    logic [7:0]  v_up [WINDOW_DEPTH+1];
    logic        v_plain [WINDOW_DEPTH+1];
    logic        sep [WINDOW_DEPTH+1];
    logic        le_from [WINDOW_DEPTH+1];
    logic        before_ok [WINDOW_DEPTH+1];
    logic        term_sp [WINDOW_DEPTH+1];
    logic        term_le [WINDOW_DEPTH+1];
    logic        new_space;

    assign new_space = is_space(new_entry.ch);

    // Window view: stored cells with the incoming byte at position cnt
    always_comb
    begin
        for (int j = 0; j <= WINDOW_DEPTH; j++)
        begin
            if (j < WINDOW_DEPTH)
                v[j] = cells[j];
            else
                v[j] = '0;
            if (accept && (cnt == CNT_W'(j)))
                v[j] = new_entry;
        end
    end

    // Per-position tests
    always_comb
    begin
        for (int j = 0; j <= WINDOW_DEPTH; j++)
        begin
            v_up[j]    = upper_ascii(v[j].ch);
            v_plain[j] = v[j].valid && (v[j].cls == CLS_PLAIN);
            sep[j]     = v[j].valid && (is_space(v[j].ch) || v[j].le);
            term_sp[j] = accept && new_space && (cnt == CNT_W'(j + 1));
            term_le[j] = accept && new_entry.le && (cnt == CNT_W'(j));
        end
    end

    // Stored line end at or after each position; left context of each start
    always_comb
    begin
        le_from[WINDOW_DEPTH] = 1'b0;
        for (int s = WINDOW_DEPTH - 1; s >= 0; s--)
            le_from[s] = le_from[s+1] | (cells[s].valid & cells[s].le);
        before_ok[0] = before_space;
        for (int s = 1; s <= WINDOW_DEPTH; s++)
            before_ok[s] = sep[s-1];
    end

    // Keyword hits for every start position and word
    always_comb
    begin
        int   n;
        int   e;
        logic m;
        logic t_sp;
        mark_kw = '0;
        new_kw  = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            for (int s = 0; s <= WINDOW_DEPTH; s++)
            begin
                n = KW_LEN[k];
                e = s + n - 1;
                if (e <= WINDOW_DEPTH)
                begin
                    m = before_ok[s] && !le_from[s];
                    for (int i = 0; i < KW_MAX; i++)
                    begin
                        if ((i < n) && (s + i <= WINDOW_DEPTH))
                            m = m && v_plain[s+i] && (v_up[s+i] == KW_CHARS[k][i]);
                    end
                    t_sp = (e < WINDOW_DEPTH) ? term_sp[e] : 1'b0;
                    if (m && (t_sp || term_le[e]))
                    begin
                        for (int i = 0; i < KW_MAX; i++)
                        begin
                            if ((i < n) && (s + i < WINDOW_DEPTH))
                                mark_kw[s+i] = 1'b1;
                        end
                    end
                    // a line-end hit always covers the incoming byte
                    if (m && term_le[e])
                        new_kw = 1'b1;
                end
            end
        end
    end

    // "!=": mark the bang just before an operator '='
    always_comb
    begin
        for (int j = 0; j < WINDOW_DEPTH; j++)
        begin
            mark_op[j] = accept && (new_entry.ch == CH_EQUAL) &&
                         (new_entry.cls == CLS_OPERATOR) && (cnt == CNT_W'(j + 1)) &&
                         cells[j].valid && !cells[j].le && (cells[j].ch == CH_BANG) &&
                         (cells[j].cls == CLS_PLAIN);
        end
    end

endmodule

// File: hw/rtl/sql_token_classifier.sv
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, when the output side keeps up.
// Release: a byte leaves the cell chain once six more bytes of its line have
// been accepted or the last byte of its line has been accepted, then passes
// the result register. A line's tail drains at one per cycle if output keeps up.
// Reset: asynchronous, active low; clears the chain, string state and output.
// ----------------------------------------------------------------------------
// ============================================================================
// sql_token_classifier
// Classifies a stream of SQL text bytes as plain, keyword, operator or string
// using a chain of window cells and a parallel keyword matcher.
// ============================================================================
module sql_token_classifier
    import sqtc_pkg::*;
#(
    parameter int WINDOW_DEPTH = SQTC_WINDOW_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    sqtc_in_if.sink    text_in,
    sqtc_out_if.source class_out
);

    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int FINAL_CNT = KW_MAX + 1;

    // String tracking
    logic in_string_reg, in_string_next;
    logic escape_reg, escape_next;

    // Window occupancy and left context of the oldest cell
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             bis_reg, bis_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    sqtc_class_t out_class_reg;
    logic        out_le_reg;

    // Chain signals
    sqtc_entry_t      cell_raw  [WINDOW_DEPTH];
    sqtc_entry_t      cell_view [WINDOW_DEPTH];
    sqtc_entry_t      nbr_view  [WINDOW_DEPTH];
    sqtc_cell_ctl_t   cell_ctl  [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] mark_kw, mark_op;
    logic             new_kw;
    sqtc_entry_t      new_base, new_marked;
    sqtc_class_t      base_cls;
    logic [CNT_W-1:0] load_pos;

    logic any_le, head_final, pop, accept;

    // Base class of the incoming byte and string state update
    always_comb
    begin
        in_string_next = in_string_reg;
        escape_next    = escape_reg;
        if (in_string_reg)
        begin
            base_cls = CLS_STRING;
            if (!escape_reg && (text_in.text_byte == CH_QUOTE))
                in_string_next = 1'b0;
            escape_next = (text_in.text_byte == CH_BSLASH);
        end
        else if (text_in.text_byte == CH_QUOTE)
        begin
            base_cls       = CLS_STRING;
            in_string_next = 1'b1;
            escape_next    = 1'b0;
        end
        else
        begin
            base_cls = is_single_op(text_in.text_byte) ? CLS_OPERATOR : CLS_PLAIN;
        end
        if (text_in.line_end)
            escape_next = 1'b0;
    end

    assign new_base = '{valid: 1'b1, ch: text_in.text_byte, cls: base_cls,
                        le: text_in.line_end};

    always_comb
    begin
        new_marked = new_base;
        if (new_kw)
            new_marked.cls = CLS_KEYWORD;
    end

    // Head release: class settled by a line end in the chain or enough successors
    always_comb
    begin
        any_le = 1'b0;
        for (int j = 0; j < WINDOW_DEPTH; j++)
            any_le = any_le | (cell_raw[j].valid & cell_raw[j].le);
    end

    assign head_final = any_le || (cnt_reg >= CNT_W'(FINAL_CNT));
    assign pop        = cell_raw[0].valid && head_final && (!out_valid_reg || class_out.ready);

    // Input handshake
    assign text_in.ready = (cnt_reg < CNT_W'(WINDOW_DEPTH)) || pop;
    assign accept        = text_in.valid && text_in.ready;

    // Keyword and bang marks
    sqtc_matcher #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_matcher (
        .cells        (cell_raw),
        .new_entry    (new_base),
        .accept       (accept),
        .cnt          (cnt_reg),
        .before_space (bis_reg),
        .mark_kw      (mark_kw),
        .mark_op      (mark_op),
        .new_kw       (new_kw)
    );

    // Cell controls: whole chain shifts on a pop, new byte lands after the last entry
    assign load_pos = cnt_reg - CNT_W'(pop);

    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            cell_ctl[i].shift   = pop;
            cell_ctl[i].load    = accept && (load_pos == CNT_W'(i));
            cell_ctl[i].mark_kw = mark_kw[i];
            cell_ctl[i].mark_op = mark_op[i];
        end
    end

    // Cell chain
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        if (i < WINDOW_DEPTH - 1)
        begin : g_nbr
            assign nbr_view[i] = cell_view[i+1];
        end
        else
        begin : g_tail
            assign nbr_view[i] = '0;
        end

        sqtc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[i]),
            .nbr_view  (nbr_view[i]),
            .new_entry (new_marked),
            .entry     (cell_raw[i]),
            .view      (cell_view[i])
        );
    end

    // Occupancy and left context
    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(accept) - CNT_W'(pop);
        bis_next = bis_reg;
        if (pop)
            bis_next = cell_view[0].le ? 1'b1 : is_space(cell_view[0].ch);
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (class_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg <= 1'b0;
            escape_reg    <= 1'b0;
            cnt_reg       <= '0;
            bis_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_string_reg <= in_string_next;
                escape_reg    <= escape_next;
            end
            cnt_reg       <= cnt_next;
            bis_reg       <= bis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg  <= cell_view[0].ch;
            out_class_reg <= cell_view[0].cls;
            out_le_reg    <= cell_view[0].le;
        end
    end

    assign class_out.valid        = out_valid_reg;
    assign class_out.out_byte     = out_byte_reg;
    assign class_out.char_class   = out_class_reg;
    assign class_out.out_line_end = out_le_reg;

endmodule

// File: sim/tb_sql_token_classifier.sv
// ============================================================================
// tb_sql_token_classifier
// Self-checking testbench for the SQL token classifier. Text is sent line by
// line through the input channel. A behavioral copy of the classifier
// predicts the class of every byte, and each output transaction is checked
// against the oldest prediction. Both channels stall in random bursts.
// ============================================================================
module tb_sql_token_classifier
    import sqtc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH    = 7;
    localparam int KW_TOTAL     = 21;
    localparam int RANDOM_BYTES = 385;
    localparam int QUIET_TAIL   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // One classified byte as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] cls;
        logic       le;
    } token_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sqtc_in_if  text_in ();
    sqtc_out_if class_out ();

    sql_token_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .class_out (class_out)
    );

    always #5 clk = ~clk;

    token_byte_t expected_tokens[$];
    logic [7:0]  line_buf[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          sent_count  = 0;
    bit          idle_on     = 1'b1;

    // Classifier state: string tracking and the lookahead window
    logic [7:0]  win_ch  [WIN_DEPTH];
    sqtc_class_t win_cls [WIN_DEPTH];
    int          win_fill   = 0;
    bit          in_str     = 1'b0;
    bit          esc_seen   = 1'b0;
    bit          lead_blank = 1'b1;

    // ------------------------------------------------------------------------
    // Byte tests and keyword list
    // ------------------------------------------------------------------------
    function automatic bit is_blank(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        if ((c >= "a") && (c <= "z"))
            return c & 8'hDF;
        return c;
    endfunction

    function automatic bit op_char(logic [7:0] c);
        case (c)
            "*", "/", "+", "-", "%", "=", ";", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string keyword_text(int k);
        case (k)
            0:  return "ALTER";
            1:  return "AND";
            2:  return "AS";
            3:  return "ASC";
            4:  return "BY";
            5:  return "DELETE";
            6:  return "DESC";
            7:  return "DROP";
            8:  return "FROM";
            9:  return "INNER";
            10: return "INSERT";
            11: return "IS";
            12: return "JOIN";
            13: return "LEFT";
            14: return "NULL";
            15: return "ON";
            16: return "OR";
            17: return "ORDER";
            18: return "RIGHT";
            19: return "SELECT";
            default: return "WHERE";
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Keyword marking: a word ending just before window slot 'stop', with a
    // blank or the line start in front of it
    // ------------------------------------------------------------------------
    function automatic void mark_words(int stop);
        int         n;
        int         k;
        int         i;
        int         start;
        bit         left_blank;
        bit         hit;
        string      kw;
        logic [7:0] kc;
        for (n = 2; (n <= 6) && (n <= stop); n++)
        begin
            start      = stop - n;
            left_blank = (start > 0) ? is_blank(win_ch[start-1]) : lead_blank;
            if (left_blank)
            begin
                hit = 1'b0;
                for (k = 0; (k < KW_TOTAL) && !hit; k++)
                begin
                    kw = keyword_text(k);
                    if (kw.len() == n)
                    begin
                        hit = 1'b1;
                        for (i = 0; i < n; i++)
                        begin
                            kc = kw[i];
                            if ((win_cls[start+i] != CLS_PLAIN) ||
                                (to_upper(win_ch[start+i]) != kc))
                                hit = 1'b0;
                        end
                        if (hit)
                            for (i = 0; i < n; i++)
                                win_cls[start+i] = CLS_KEYWORD;
                    end
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Classify one accepted byte and queue the bytes it releases
    // ------------------------------------------------------------------------
    function automatic void classify_byte(logic [7:0] b, logic last);
        sqtc_class_t c;
        int          idx;
        int          k;
        token_byte_t tok;
        // string state first
        if (in_str)
        begin
            c = CLS_STRING;
            if (!esc_seen && (b == CH_QUOTE))
                in_str = 1'b0;
            esc_seen = (b == CH_BSLASH);
        end
        else if (b == CH_QUOTE)
        begin
            c        = CLS_STRING;
            in_str   = 1'b1;
            esc_seen = 1'b0;
        end
        else
            c = op_char(b) ? CLS_OPERATOR : CLS_PLAIN;

        idx          = win_fill;
        win_ch[idx]  = b;
        win_cls[idx] = c;
        win_fill     = idx + 1;

        // "!=" pair: the bang becomes an operator too
        if ((b == CH_EQUAL) && (c == CLS_OPERATOR) && (idx > 0) &&
            (win_ch[idx-1] == CH_BANG) && (win_cls[idx-1] == CLS_PLAIN))
            win_cls[idx-1] = CLS_OPERATOR;

        if (is_blank(b))
            mark_words(idx);

        if (last)
        begin
            // flush the whole window
            mark_words(win_fill);
            for (k = 0; k < win_fill; k++)
            begin
                tok.ch  = win_ch[k];
                tok.cls = win_cls[k];
                tok.le  = (k == win_fill - 1);
                expected_tokens.push_back(tok);
            end
            win_fill   = 0;
            lead_blank = 1'b1;
            esc_seen   = 1'b0;
        end
        else if (win_fill == WIN_DEPTH)
        begin
            // window full: release the oldest byte
            tok.ch  = win_ch[0];
            tok.cls = win_cls[0];
            tok.le  = 1'b0;
            expected_tokens.push_back(tok);
            lead_blank = is_blank(win_ch[0]);
            for (k = 0; k < WIN_DEPTH - 1; k++)
            begin
                win_ch[k]  = win_ch[k+1];
                win_cls[k] = win_cls[k+1];
            end
            win_fill = WIN_DEPTH - 1;
        end
    endfunction

    // Predict on every input transaction
    always @(posedge clk)
    begin
        if (rst_n && text_in.valid && text_in.ready)
            classify_byte(text_in.text_byte, text_in.line_end);
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        token_byte_t want;
        if (rst_n && class_out.valid && class_out.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: out_byte %h char_class %0d",
                       class_out.out_byte, class_out.char_class);
                fail_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (class_out.out_byte !== want.ch)
                begin
                    $error("out_byte: expected %h, actual %h", want.ch, class_out.out_byte);
                    fail_count++;
                end
                if (class_out.char_class !== want.cls)
                begin
                    $error("char_class: expected %0d, actual %0d",
                           want.cls, class_out.char_class);
                    fail_count++;
                end
                if (class_out.out_line_end !== want.le)
                begin
                    $error("out_line_end: expected %0b, actual %0b",
                           want.le, class_out.out_line_end);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure in random bursts
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            class_out.ready <= 1'b0;
        end
        else if (idle_on && ($urandom_range(0, 6) == 0))
        begin
            stall_left = $urandom_range(1, 9) - 1;
            class_out.ready <= 1'b0;
        end
        else
            class_out.ready <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Send one byte; returns at the edge where the transaction completes
    task automatic send_char(input logic [7:0] b, input logic last);
        int gap;
        if (idle_on && ($urandom_range(0, 5) == 0))
        begin
            gap = $urandom_range(1, 9);
            text_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_in.valid     <= 1'b1;
        text_in.text_byte <= b;
        text_in.line_end  <= last;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic push_blanks();
        int n;
        int r;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(0, 6);
            line_buf.push_back((r > 4) ? 8'h20 : 8'(9 + r));
        end
    endtask

    // One token of random SQL-like text
    task automatic push_token();
        string      s;
        string      ops;
        int         i;
        int         n;
        logic [7:0] c;
        ops = "*/+-%=;<>!";
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                // keyword in random case
                s = keyword_text($urandom_range(0, KW_TOTAL - 1));
                for (i = 0; i < s.len(); i++)
                begin
                    c = s[i];
                    line_buf.push_back($urandom_range(0, 1) ? (c | 8'h20) : c);
                end
                if ($urandom_range(0, 3) != 0)
                    push_blanks();
            end
            4:
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    c = 8'($urandom_range(0, 25)) + "a";
                    line_buf.push_back($urandom_range(0, 1) ? (c & 8'hDF) : c);
                end
                if ($urandom_range(0, 1))
                    push_blanks();
            end
            5, 6:
                push_blanks();
            7:
            begin
                case ($urandom_range(0, 12))
                    10: push_str("!=");
                    11: push_str("<>");
                    12: push_str("<=");
                    default: line_buf.push_back(ops[$urandom_range(0, 9)]);
                endcase
            end
            8:
            begin
                // quoted text, sometimes with escapes, sometimes left open
                line_buf.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                        line_buf.push_back(CH_BSLASH);
                    else
                        line_buf.push_back(8'($urandom_range(32, 126)));
                end
                if ($urandom_range(0, 3) != 0)
                    line_buf.push_back(CH_QUOTE);
            end
            default:
                line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Keyword filling a whole line: both line edges count as blanks
    task automatic test_line_edge_keyword();
        push_str("oR");
        send_line();
    endtask

    // All single operators, a "!=" pair and a lone bang at the line end
    task automatic test_operators();
        push_str("*/+-%=;<>!=!");
        send_line();
    endtask

    // Escaped quote keeps the string open across the line end; a quote after
    // two backslashes is still escaped, the next one closes
    task automatic test_strings_across_lines();
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(CH_BSLASH);
        line_buf.push_back(CH_QUOTE);
        send_line();
        line_buf.push_back(CH_BSLASH);
        line_buf.push_back(CH_BSLASH);
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(CH_QUOTE);
        send_line();
    endtask

    task automatic test_byte_extremes();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line();
    endtask

    task automatic test_random_text();
        int stop_at;
        int target;
        stop_at = sent_count + RANDOM_BYTES;
        while (sent_count < stop_at)
        begin
            // quiet stretches now and then, none at all near the end
            idle_on = (stop_at - sent_count > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            target  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 16);
            while (line_buf.size() < target)
                push_token();
            send_line();
        end
        idle_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        text_in.valid     <= 1'b0;
        text_in.text_byte <= 8'h00;
        text_in.line_end  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_edge_keyword();
        test_operators();
        test_strings_across_lines();
        test_byte_extremes();
        test_random_text();

        text_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
